### hdl/bde_pkg.sv
// Shared types and constants for the bounded deque engine.
package bde_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 64;
	localparam int DEPTH_MAX = 64;
	localparam int CNT_W     = $clog2(DEPTH_MAX + 1);

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_DUMP       = 3'd4,
		CMD_CLEAR      = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD      = 3'd0,
		OP_SHIFT_IN  = 3'd1,
		OP_SHIFT_OUT = 3'd2,
		OP_WRITE_AT  = 3'd3,
		OP_ROTATE    = 3'd4
	} chain_op_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_DUMP = 1'b1
	} state_t;

	typedef struct packed {
		chain_op_t        op;
		logic [CNT_W-1:0] count;
	} chain_ctl_t;

endpackage

### hdl/bde_cell.sv
// One storage cell of the deque chain.
module bde_cell #(
	parameter int INDEX = 0
) (
	input  logic                        clk,
	input  bde_pkg::chain_ctl_t         ctl,
	input  logic [bde_pkg::DATA_W-1:0]  left_data,
	input  logic [bde_pkg::DATA_W-1:0]  right_data,
	input  logic [bde_pkg::DATA_W-1:0]  head_data,
	input  logic [bde_pkg::DATA_W-1:0]  push_data,
	output logic [bde_pkg::DATA_W-1:0]  data
);
	import bde_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;
	logic              at_count;
	logic              is_last;
	logic              below_last;

	assign at_count   = (ctl.count == CNT_W'(INDEX));
	assign is_last    = (ctl.count == CNT_W'(INDEX + 1));
	assign below_last = (CNT_W'(INDEX + 1) < ctl.count);

	always_comb begin
		data_d = data_q;
		unique case (ctl.op)
			OP_HOLD:      data_d = data_q;
			OP_SHIFT_IN:  data_d = left_data;
			OP_SHIFT_OUT: data_d = right_data;
			OP_WRITE_AT:  data_d = at_count ? push_data : data_q;
			OP_ROTATE: begin
				// wrap the head around to the tail, advance the rest
				if (is_last)
					data_d = head_data;
				else if (below_last)
					data_d = right_data;
				else
					data_d = data_q;
			end
			default:      data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

### hdl/bde_chain.sv
// Row of deque cells; entry zero sits at the head.
module bde_chain #(
	parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  bde_pkg::chain_ctl_t         ctl,
	input  logic [bde_pkg::DATA_W-1:0]  push_data,
	output logic [bde_pkg::DATA_W-1:0]  head
);
	import bde_pkg::*;

	logic [DATA_W-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_in;
		logic [DATA_W-1:0] right_in;

		if (i == 0) begin : g_first
			assign left_in = push_data;
		end else begin : g_inner_l
			assign left_in = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_final
			assign right_in = cell_data[i];
		end else begin : g_inner_r
			assign right_in = cell_data[i+1];
		end

		bde_cell #(
			.INDEX(i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.left_data  (left_in),
			.right_data (right_in),
			.head_data  (cell_data[0]),
			.push_data  (push_data),
			.data       (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

### hdl/bounded_deque_engine.sv
// Top level of the bounded deque engine: command decode, counters and result register.
module bounded_deque_engine #(
	parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          cmd,
	input  logic signed [bde_pkg::DATA_W-1:0]   value,
	output logic                                strobe,
	output logic signed [bde_pkg::DATA_W-1:0]   value_res,
	output logic [1:0]                          status,
	output logic                                last
);
	// A bounded double-ended queue of DEPTH signed 32-bit values (2 to 64).
	// A transaction is taken at a rising edge with start high and busy low.
	// Push front, push back, pop front, pop back and clear may be issued
	// back to back; their single result shows
	// on the result ports, marked by strobe, in the cycle after acceptance.
	// A dump of n entries (n > 0) streams n results, front first, on
	// consecutive cycles, each passing through the S_DUMP state and the
	// result register, with last set on the final one; busy stays high
	// while the entries are read out. The rate is set by the chain
	// of storage cells, which rotates one entry past the head per cycle.
	// Pop or dump on an empty queue gives one result with status empty; a
	// push into a full queue gives status full and drops the value. Codes 6
	// and 7 are ignored and give no result. Results are held one cycle only:
	// the receiver must take each one as it appears, there is no back-pressure.
	//
	// Storage is two chains of cells. Chain A keeps entries front to back
	// from cell zero; chain B keeps them back to front. Each pop reads the
	// head of one chain and shifts it, while the other chain simply loses
	// its tail entry when the count drops. Cells at or beyond the count are
	// stale and never read.

	import bde_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic [CNT_W-1:0]   dump_left_q;
	logic [CNT_W-1:0]   dump_left_d;

	chain_ctl_t         ctl_a;
	chain_ctl_t         ctl_b;
	logic [DATA_W-1:0]  head_a;
	logic [DATA_W-1:0]  head_b;
	logic [DATA_W-1:0]  push_data;

	logic               accept;
	logic               full;
	logic               empty;

	logic               res_valid;
	logic [DATA_W-1:0]  res_value;
	status_t            res_status;
	logic               res_last;

	logic                      strobe_q;
	logic signed [DATA_W-1:0]  value_res_q;
	status_t                   status_q;
	logic                      last_q;

	assign busy      = (state_q == S_DUMP);
	assign accept    = start && !busy;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign push_data = value;

	// Storage chains
	bde_chain #(
		.DEPTH(DEPTH)
	) u_chain_a (
		.clk       (clk),
		.ctl       (ctl_a),
		.push_data (push_data),
		.head      (head_a)
	);

	bde_chain #(
		.DEPTH(DEPTH)
	) u_chain_b (
		.clk       (clk),
		.ctl       (ctl_b),
		.push_data (push_data),
		.head      (head_b)
	);

	// State register and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dump_left_q <= '0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			dump_left_q <= dump_left_d;
		end
	end

	// Decode the transaction, steer both chains and build the result
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		dump_left_d = dump_left_q;
		ctl_a.op    = OP_HOLD;
		ctl_a.count = count_q;
		ctl_b.op    = OP_HOLD;
		ctl_b.count = count_q;
		res_valid   = 1'b0;
		res_value   = '0;
		res_status  = ST_OK;
		res_last    = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_PUSH_FRONT: begin
							res_valid = 1'b1;
							if (full) begin
								res_status = ST_FULL;
							end else begin
								// new front enters at A's head and at B's tail
								ctl_a.op = OP_SHIFT_IN;
								ctl_b.op = OP_WRITE_AT;
								count_d  = count_q + CNT_W'(1);
							end
						end
						CMD_PUSH_BACK: begin
							res_valid = 1'b1;
							if (full) begin
								res_status = ST_FULL;
							end else begin
								ctl_a.op = OP_WRITE_AT;
								ctl_b.op = OP_SHIFT_IN;
								count_d  = count_q + CNT_W'(1);
							end
						end
						CMD_POP_FRONT: begin
							res_valid = 1'b1;
							if (empty) begin
								res_status = ST_EMPTY;
							end else begin
								res_value = head_a;
								ctl_a.op  = OP_SHIFT_OUT;
								count_d   = count_q - CNT_W'(1);
							end
						end
						CMD_POP_BACK: begin
							res_valid = 1'b1;
							if (empty) begin
								res_status = ST_EMPTY;
							end else begin
								res_value = head_b;
								ctl_b.op  = OP_SHIFT_OUT;
								count_d   = count_q - CNT_W'(1);
							end
						end
						CMD_DUMP: begin
							if (empty) begin
								res_valid  = 1'b1;
								res_status = ST_EMPTY;
							end else begin
								state_d     = S_DUMP;
								dump_left_d = count_q;
							end
						end
						CMD_CLEAR: begin
							res_valid = 1'b1;
							count_d   = '0;
						end
						default: begin
							// undefined code: drop it silently
						end
					endcase
				end
			end
			S_DUMP: begin
				// emit A's head and rotate it to the tail; n rotations restore order
				res_valid   = 1'b1;
				res_value   = head_a;
				ctl_a.op    = OP_ROTATE;
				res_last    = (dump_left_q == CNT_W'(1));
				dump_left_d = dump_left_q - CNT_W'(1);
				if (res_last)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Result register: hold each result for exactly one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		value_res_q <= $signed(res_value);
		status_q    <= res_status;
		last_q      <= res_last;
	end

	assign strobe    = strobe_q;
	assign value_res = value_res_q;
	assign status    = status_q;
	assign last      = last_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_dump_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> (dump_left_q != '0) && (dump_left_q <= count_q))
		else $error("dump counter out of range");

	a_dump_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> strobe && (status == ST_OK))
		else $error("dump cycle without ok result");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> $stable(count_q))
		else $error("entry count moved without a transaction");

	a_strobe_cause: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy) || $past(state_q == S_DUMP))
		else $error("result without a transaction");
`endif

endmodule

### verif/bde_checker.sv
`timescale 1ns / 100ps
// Deque checker: watches the command and result channels, predicts results and compares them.
module bde_checker #(
	parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [2:0]                        cmd,
	input  logic signed [bde_pkg::DATA_W-1:0] value,
	input  logic                              strobe,
	input  logic signed [bde_pkg::DATA_W-1:0] value_res,
	input  logic [1:0]                        status,
	input  logic                              last,
	output int                                errors = 0,
	output int                                pending = 0
);
	import bde_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		status_t                  code;
		logic                     last;
	} deque_result_t;

	logic [DATA_W-1:0] slots [DEPTH];
	logic [IDX_W-1:0]  head = '0;
	logic [CNT_W-1:0]  fill = '0;
	deque_result_t     expected_results [$];

	function automatic void expect_result(input logic signed [DATA_W-1:0] data,
			input status_t code, input logic fin);
		deque_result_t r;
		r.data = data;
		r.code = code;
		r.last = fin;
		expected_results.push_back(r);
	endfunction

	// Apply one command to the shadow deque and queue up the results it causes.
	task automatic predict_deque_op(input logic [2:0] op, input logic signed [DATA_W-1:0] data);
		logic signed [DATA_W-1:0] taken;
		case (op)
		CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
			if (fill >= DEPTH) begin
				expect_result('0, ST_FULL, 1'b1);
			end else begin
				if (op == CMD_PUSH_FRONT) begin
					head = IDX_W'((int'(head) + DEPTH - 1) % DEPTH);
					slots[head] = data;
				end else begin
					slots[(int'(head) + int'(fill)) % DEPTH] = data;
				end
				fill++;
				expect_result('0, ST_OK, 1'b1);
			end
		end
		CMD_POP_FRONT, CMD_POP_BACK: begin
			if (fill == 0) begin
				expect_result('0, ST_EMPTY, 1'b1);
			end else begin
				if (op == CMD_POP_FRONT) begin
					taken = slots[head];
					head = IDX_W'((int'(head) + 1) % DEPTH);
				end else begin
					taken = slots[(int'(head) + int'(fill) - 1) % DEPTH];
				end
				fill--;
				expect_result(taken, ST_OK, 1'b1);
			end
		end
		CMD_DUMP: begin
			if (fill == 0)
				expect_result('0, ST_EMPTY, 1'b1);
			for (int i = 0; i < int'(fill); i++)
				expect_result(slots[(int'(head) + i) % DEPTH], ST_OK, i == int'(fill) - 1);
		end
		CMD_CLEAR: begin
			fill = '0;
			head = '0;
			expect_result('0, ST_OK, 1'b1);
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		deque_result_t exp_r;
		int            nerr;
		nerr = 0;
		if (!arst_n) begin
			head = '0;
			fill = '0;
			expected_results.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (start && !busy)
				predict_deque_op(cmd, value);
			if (strobe) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: value_res %0d, status %0d, last %0d",
						value_res, status, last);
					nerr++;
				end else begin
					exp_r = expected_results.pop_front();
					if (value_res !== exp_r.data) begin
						$error("value_res: expected %0d, got %0d", exp_r.data, value_res);
						nerr++;
					end
					if (status !== exp_r.code) begin
						$error("status: expected %0d, got %0d", exp_r.code, status);
						nerr++;
					end
					if (last !== exp_r.last) begin
						$error("last: expected %0d, got %0d", exp_r.last, last);
						nerr++;
					end
				end
			end
			errors  <= errors + nerr;
			pending <= expected_results.size();
		end
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, command stimulus and verdict for the bounded deque engine.
module testbench;
	import bde_pkg::*;

	localparam int QDEPTH        = DEPTH_DEF;
	localparam int RANDOM_OPS    = 200;
	localparam int FILL_EPISODES = 2;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 16;

	// Command codes the block leaves undefined; it must swallow them silently.
	localparam logic [2:0] CMD_RSVD_LO = 3'd6;
	localparam logic [2:0] CMD_RSVD_HI = 3'd7;

	logic                     clk    = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start  = 1'b0;
	logic [2:0]               cmd    = CMD_CLEAR;
	logic signed [DATA_W-1:0] value  = '0;
	logic                     busy;
	logic                     strobe;
	logic signed [DATA_W-1:0] value_res;
	logic [1:0]               status;
	logic                     last;

	int fail_count;
	int pending;
	int cycles     = 0;
	int burst_left = 0;
	int ops_issued = 0;

	always #5 clk = ~clk;

	bounded_deque_engine #(
		.DEPTH(QDEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.value    (value),
		.strobe   (strobe),
		.value_res(value_res),
		.status   (status),
		.last     (last)
	);

	bde_checker #(
		.DEPTH(QDEPTH)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.value    (value),
		.strobe   (strobe),
		.value_res(value_res),
		.status   (status),
		.last     (last),
		.errors   (fail_count),
		.pending  (pending)
	);

	// Watchdog: end the run if the block hangs or results never drain.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Bias values toward the extremes and small magnitudes of both signs.
	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
		0: return 32'sh7FFF_FFFF;
		1: return 32'sh8000_0000;
		2: return $urandom_range(0, 15);
		3: return ~DATA_W'($urandom_range(0, 15));
		default: return $urandom;
		endcase
	endfunction

	// Mostly pushes and pops, with dumps, clears and undefined codes mixed in.
	function automatic logic [2:0] pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 24) return CMD_PUSH_FRONT;
		if (r < 48) return CMD_PUSH_BACK;
		if (r < 64) return CMD_POP_FRONT;
		if (r < 80) return CMD_POP_BACK;
		if (r < 89) return CMD_DUMP;
		if (r < 94) return CMD_CLEAR;
		return $urandom_range(0, 1) ? CMD_RSVD_HI : CMD_RSVD_LO;
	endfunction

	// Offer one transaction and hold it until the block takes it. Between bursts,
	// drop start for a random gap; some bursts follow back to back with no gap.
	task automatic issue(input logic [2:0] op, input logic signed [DATA_W-1:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		start <= 1'b1;
		cmd   <= op;
		value <= data;
		do @(posedge clk); while (busy);
		burst_left--;
		ops_issued++;
	endtask

	initial begin
		int n;
		int episodes;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-queue pops and dump, undefined codes, extreme values,
		// front pointer wrapping below zero, dump of a few entries, clear.
		issue(CMD_POP_FRONT, 32'sh1234_5678);
		issue(CMD_POP_BACK, 32'sh8000_0000);
		issue(CMD_DUMP, 32'sh7FFF_FFFF);
		issue(CMD_RSVD_LO, 32'sh0BAD_0006);
		issue(CMD_RSVD_HI, 32'sh0BAD_0007);
		issue(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
		issue(CMD_PUSH_FRONT, 32'sh8000_0000);
		issue(CMD_PUSH_BACK, -32'sd1);
		issue(CMD_PUSH_FRONT, 32'sd0);
		issue(CMD_DUMP, -32'sd1);
		issue(CMD_POP_FRONT, 32'sd0);
		issue(CMD_POP_BACK, 32'sd0);
		issue(CMD_DUMP, 32'sd0);
		issue(CMD_CLEAR, 32'sh7FFF_FFFF);
		issue(CMD_DUMP, 32'sd0);
		issue(CMD_PUSH_FRONT, 32'sd1);
		issue(CMD_CLEAR, -32'sd1);
		issue(CMD_POP_BACK, 32'sd0);
		issue(CMD_PUSH_BACK, 32'sh5555_AAAA);
		issue(CMD_PUSH_BACK, 32'shAAAA_5555);
		issue(CMD_POP_BACK, 32'sd0);
		issue(CMD_POP_FRONT, 32'sd0);
		issue(CMD_POP_FRONT, 32'sd0);

		// Random: short segments of mixed, push-heavy and pop-heavy traffic, with
		// fill episodes at fixed points that overrun the queue, dump it whole and
		// drain between a quarter and all of it again.
		ops_issued = 0;
		episodes   = 0;
		while (ops_issued < RANDOM_OPS) begin
			if (episodes < FILL_EPISODES && ops_issued >= episodes * 100 + 20) begin
				repeat (QDEPTH + 2)
					issue($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, rand_value());
				issue(CMD_DUMP, rand_value());
				n = $urandom_range(QDEPTH / 4, QDEPTH);
				repeat (n)
					issue($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, rand_value());
				episodes++;
			end else begin
				n = $urandom_range(4, 16);
				case ($urandom_range(0, 5))
				3: begin
					repeat (n)
						issue($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
							rand_value());
				end
				4: begin
					repeat (n)
						issue($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT,
							rand_value());
				end
				5: begin
					issue($urandom_range(0, 1) ? CMD_DUMP : CMD_CLEAR, rand_value());
				end
				default: begin
					repeat (n) issue(pick_cmd(), rand_value());
				end
				endcase
			end
		end

		// Drop start, wait for every expected result, then let the block settle.
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
